>>> rtl/npt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package npt_pkg;

    // table geometry
    localparam int TABLE_SLOTS = 16;
    localparam int SLOT_IDX_W  = $clog2(TABLE_SLOTS);
    // scan counter holds TABLE_SLOTS + 1, the last drain step of the pipeline
    localparam int SCAN_CNT_W  = $clog2(TABLE_SLOTS + 2);

    // field widths
    localparam int MAC_W      = 48;
    localparam int TIME_W     = 32;
    localparam int SIGHT_W    = 8;
    localparam int STATUS_W   = 2;
    localparam int COUNT_W    = 5;
    localparam int OUT_IDX_W  = 4;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 32;

    localparam int IN_TDATA_W  = MAC_W + TIME_W;
    localparam int OUT_TDATA_W = 2 * COUNT_W + OUT_IDX_W + STATUS_W;

    localparam logic [SIGHT_W-1:0] SIGHT_MAX = '1;
    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

    // entry status codes
    localparam logic [STATUS_W-1:0] ST_CANDIDATE = 2'd0;
    localparam logic [STATUS_W-1:0] ST_CONFIRMED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_STALE     = 2'd2;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_CONFIRM_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_STALE_AFTER_MS    = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_REMOVE_AFTER_MS   = 2'd2;

    // reset values of the configuration registers
    localparam logic [SIGHT_W-1:0] CONFIRM_THRESHOLD_RST = 8'd3;
    localparam logic [TIME_W-1:0]  STALE_AFTER_MS_RST    = 32'd5000;
    localparam logic [TIME_W-1:0]  REMOVE_AFTER_MS_RST   = 32'd15000;

    // controller to datapath commands
    typedef struct packed {
        logic                  accept;
        logic                  issue;
        logic [SLOT_IDX_W-1:0] addr;
        logic                  update;
        logic                  load_out;
    } npt_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic sweep;
        logic out_free;
    } npt_sts_t;

endpackage

`default_nettype wire

>>> rtl/neighbor_presence_table_top.sv
// channel   direction  handshake                    payload
// s_axis    in         s_axis_tvalid/s_axis_tready  tdata: neighbor_mac, now_ms; tuser: action
// m_axis    out        m_axis_tvalid/m_axis_tready  tdata: counts, slot_index, entry_status;
//                                                   tuser: slot_valid
// cfg       in         cfg_valid/cfg_ready          cfg_index, cfg_data
//
// a note passes from input transfer to result transfer through a scan of one entry per
// cycle, its drain through the read and age stages, an update step and the output load;
// a sweep skips the update step
// one item is in work at a time; ready returns when its result is loaded into the output
// register, and a later result waits in the finish step while that one is stalled
// reset clears the used bits, totals and registers; no clearing pass is needed
// cfg_ready is always high
`timescale 1ns / 1ps
`default_nettype none

module neighbor_presence_table_top
    import npt_pkg::*;
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  s_axis_tvalid,
    output logic                       s_axis_tready,
    input  wire logic [IN_TDATA_W-1:0] s_axis_tdata,  // neighbor_mac, now_ms
    input  wire logic                  s_axis_tuser,  // action
    output logic                       m_axis_tvalid,
    input  wire logic                  m_axis_tready,
    // present_count, confirmed_count, slot_index, entry_status
    output logic [OUT_TDATA_W-1:0]     m_axis_tdata,
    output logic                       m_axis_tuser,  // slot_valid
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data
);

    npt_cmd_t cmd;
    npt_sts_t sts;

    // configuration is taken in any cycle
    assign cfg_ready = 1'b1;

    npt_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    npt_datapath u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .sts           (sts),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .cfg_valid     (cfg_valid),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

>>> rtl/npt_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module npt_ctrl
    import npt_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     s_axis_tvalid,
    output logic          s_axis_tready,
    input  wire npt_sts_t sts,
    output npt_cmd_t      cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_UPDATE,
        S_FINISH
    } state_t;

    localparam logic [SCAN_CNT_W-1:0] CNT_SLOTS = SCAN_CNT_W'(TABLE_SLOTS);
    localparam logic [SCAN_CNT_W-1:0] CNT_LAST  = SCAN_CNT_W'(TABLE_SLOTS + 1);

    state_t                state_reg;
    logic [SCAN_CNT_W-1:0] cnt_reg;
    logic                  ready_reg;
    logic                  accept;

    assign accept        = (state_reg == S_IDLE) && s_axis_tvalid && ready_reg;
    assign s_axis_tready = ready_reg;

    // commands decoded from state, scan position, input valid and output room
    assign cmd.accept   = accept;
    assign cmd.issue    = (state_reg == S_SCAN) && (cnt_reg < CNT_SLOTS);
    assign cmd.addr     = cnt_reg[SLOT_IDX_W-1:0];
    assign cmd.update   = (state_reg == S_UPDATE);
    assign cmd.load_out = (state_reg == S_FINISH) && sts.out_free;

    // state, scan counter and ready
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            cnt_reg   <= '0;
            ready_reg <= 1'b1;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (accept)
                    begin
                        state_reg <= S_SCAN;
                        cnt_reg   <= '0;
                        ready_reg <= 1'b0;
                    end
                end
                S_SCAN:
                begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == CNT_LAST)
                    begin
                        state_reg <= sts.sweep ? S_FINISH : S_UPDATE;
                    end
                end
                S_UPDATE:
                begin
                    state_reg <= S_FINISH;
                end
                S_FINISH:
                begin
                    if (sts.out_free)
                    begin
                        state_reg <= S_IDLE;
                        ready_reg <= 1'b1;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                    ready_reg <= 1'b1;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

>>> rtl/npt_datapath.sv
`timescale 1ns / 1ps
`default_nettype none

module npt_datapath
    import npt_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire npt_cmd_t               cmd,
    output npt_sts_t                    sts,
    input  wire logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  wire logic                   s_axis_tuser,
    input  wire logic                   cfg_valid,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output logic                        m_axis_tvalid,
    input  wire logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0]      m_axis_tdata,
    output logic                        m_axis_tuser
);

    // configuration
    logic [SIGHT_W-1:0] thr_reg;
    logic [TIME_W-1:0]  stale_reg;
    logic [TIME_W-1:0]  remove_reg;

    // latched item
    logic              sweep_reg;
    logic [MAC_W-1:0]  mac_reg;
    logic [TIME_W-1:0] now_reg;

    // entry memories and used bits
    logic [MAC_W-1:0]    mac_mem    [TABLE_SLOTS];
    logic [TIME_W-1:0]   last_mem   [TABLE_SLOTS];
    logic [SIGHT_W-1:0]  sight_mem  [TABLE_SLOTS];
    logic [STATUS_W-1:0] status_mem [TABLE_SLOTS];
    logic [TABLE_SLOTS-1:0] used_reg;

    // read stage
    logic                  s1_vld_reg;
    logic [SLOT_IDX_W-1:0] s1_slot_reg;
    logic                  s1_used_reg;
    logic [MAC_W-1:0]      s1_mac_reg;
    logic [TIME_W-1:0]     s1_last_reg;
    logic [SIGHT_W-1:0]    s1_sight_reg;
    logic [STATUS_W-1:0]   s1_status_reg;

    // age stage
    logic                  s2_vld_reg;
    logic [SLOT_IDX_W-1:0] s2_slot_reg;
    logic                  s2_used_reg;
    logic [TIME_W-1:0]     s2_age_reg;
    logic [STATUS_W-1:0]   s2_status_reg;

    // note search results
    logic                  hit_reg;
    logic [SLOT_IDX_W-1:0] hit_slot_reg;
    logic [SIGHT_W-1:0]    hit_sight_reg;
    logic [STATUS_W-1:0]   hit_status_reg;
    logic                  free_reg;
    logic [SLOT_IDX_W-1:0] free_slot_reg;

    // note result and sweep totals
    logic                  res_valid_reg;
    logic [OUT_IDX_W-1:0]  res_idx_reg;
    logic [STATUS_W-1:0]   res_status_reg;
    logic [COUNT_W-1:0]    acc_present_reg;
    logic [COUNT_W-1:0]    acc_confirmed_reg;
    logic [COUNT_W-1:0]    present_reg;
    logic [COUNT_W-1:0]    confirmed_reg;

    // output register
    logic                   out_valid_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;
    logic                   out_user_reg;

    // sweep evaluation
    logic                age_remove;
    logic                age_stale;
    logic                sw_live;
    logic [STATUS_W-1:0] sw_status;

    // note update
    logic                  upd_ok;
    logic [SLOT_IDX_W-1:0] upd_slot;
    logic [SIGHT_W-1:0]    base_sight;
    logic [STATUS_W-1:0]   base_status;
    logic [SIGHT_W-1:0]    sg1;
    logic [STATUS_W-1:0]   st1;
    logic [SIGHT_W-1:0]    sg2;
    logic [STATUS_W-1:0]   st2;

    // status port write mux
    logic                  st_we;
    logic [SLOT_IDX_W-1:0] st_waddr;
    logic [STATUS_W-1:0]   st_wdata;

    assign sts.sweep    = sweep_reg;
    assign sts.out_free = !out_valid_reg || m_axis_tready;

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_user_reg;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            thr_reg    <= CONFIRM_THRESHOLD_RST;
            stale_reg  <= STALE_AFTER_MS_RST;
            remove_reg <= REMOVE_AFTER_MS_RST;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                REG_CONFIRM_THRESHOLD: thr_reg    <= cfg_data[SIGHT_W-1:0];
                REG_STALE_AFTER_MS:    stale_reg  <= cfg_data[TIME_W-1:0];
                REG_REMOVE_AFTER_MS:   remove_reg <= cfg_data[TIME_W-1:0];
                default:               ;
            endcase
        end
    end

    // input latch
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            sweep_reg <= s_axis_tuser;
            mac_reg   <= s_axis_tdata[MAC_W-1:0];
            now_reg   <= s_axis_tdata[IN_TDATA_W-1:MAC_W];
        end
    end

    // sweep age compares, removal wins over staleness
    assign age_remove = s2_age_reg > remove_reg;
    assign age_stale  = s2_age_reg > stale_reg;
    assign sw_live    = sweep_reg && s2_vld_reg && s2_used_reg;
    assign sw_status  = age_stale ? ST_STALE : s2_status_reg;

    // note update: stale re-entry, saturating count, confirmation
    always_comb
    begin
        upd_ok      = hit_reg || free_reg;
        upd_slot    = hit_reg ? hit_slot_reg : free_slot_reg;
        base_sight  = hit_reg ? hit_sight_reg : '0;
        base_status = hit_reg ? hit_status_reg : ST_CANDIDATE;
        if (base_status == ST_STALE)
        begin
            st1 = ST_CONFIRMED;
            sg1 = thr_reg;
        end
        else
        begin
            st1 = base_status;
            sg1 = base_sight;
        end
        sg2 = (sg1 != SIGHT_MAX) ? sg1 + 1'b1 : sg1;
        st2 = ((st1 != ST_CONFIRMED) && (sg2 >= thr_reg)) ? ST_CONFIRMED : st1;
    end

    // one write port on the status memory
    always_comb
    begin
        st_we    = 1'b0;
        st_waddr = s2_slot_reg;
        st_wdata = ST_STALE;
        if (cmd.update)
        begin
            st_we    = upd_ok;
            st_waddr = upd_slot;
            st_wdata = st2;
        end
        else if (sw_live && !age_remove && age_stale)
        begin
            st_we = 1'b1;
        end
    end

    // entry memories
    always_ff @(posedge clk)
    begin
        if (cmd.update && upd_ok)
        begin
            mac_mem[upd_slot]   <= mac_reg;
            last_mem[upd_slot]  <= now_reg;
            sight_mem[upd_slot] <= sg2;
        end
        if (st_we)
        begin
            status_mem[st_waddr] <= st_wdata;
        end
        if (cmd.issue)
        begin
            s1_mac_reg    <= mac_mem[cmd.addr];
            s1_last_reg   <= last_mem[cmd.addr];
            s1_sight_reg  <= sight_mem[cmd.addr];
            s1_status_reg <= status_mem[cmd.addr];
            s1_used_reg   <= used_reg[cmd.addr];
        end
        s1_slot_reg   <= cmd.addr;
        s2_slot_reg   <= s1_slot_reg;
        s2_used_reg   <= s1_used_reg;
        s2_age_reg    <= now_reg - s1_last_reg;
        s2_status_reg <= s1_status_reg;
    end

    // used bits, scan valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            used_reg   <= '0;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
        end
        else
        begin
            s1_vld_reg <= cmd.issue;
            s2_vld_reg <= s1_vld_reg;
            if (cmd.update && upd_ok)
            begin
                used_reg[upd_slot] <= 1'b1;
            end
            else if (sw_live && age_remove)
            begin
                used_reg[s2_slot_reg] <= 1'b0;
            end
        end
    end

    // note search: first matching used slot, lowest free slot
    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            hit_reg  <= 1'b0;
            free_reg <= 1'b0;
        end
        else if (!sweep_reg && s1_vld_reg)
        begin
            if (s1_used_reg && (s1_mac_reg == mac_reg) && !hit_reg)
            begin
                hit_reg        <= 1'b1;
                hit_slot_reg   <= s1_slot_reg;
                hit_sight_reg  <= s1_sight_reg;
                hit_status_reg <= s1_status_reg;
            end
            if (!s1_used_reg && !free_reg)
            begin
                free_reg      <= 1'b1;
                free_slot_reg <= s1_slot_reg;
            end
        end
    end

    // note result
    always_ff @(posedge clk)
    begin
        if (cmd.update)
        begin
            res_valid_reg  <= upd_ok;
            res_idx_reg    <= upd_ok ? OUT_IDX_W'(upd_slot) : '0;
            res_status_reg <= upd_ok ? st2 : ST_CANDIDATE;
        end
    end

    // sweep totals, saturating
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_present_reg   <= '0;
            acc_confirmed_reg <= '0;
            present_reg       <= '0;
            confirmed_reg     <= '0;
        end
        else
        begin
            if (cmd.accept)
            begin
                acc_present_reg   <= '0;
                acc_confirmed_reg <= '0;
            end
            else if (sw_live && !age_remove)
            begin
                if (acc_present_reg != COUNT_MAX)
                begin
                    acc_present_reg <= acc_present_reg + 1'b1;
                end
                if ((sw_status == ST_CONFIRMED) && (acc_confirmed_reg != COUNT_MAX))
                begin
                    acc_confirmed_reg <= acc_confirmed_reg + 1'b1;
                end
            end
            if (cmd.load_out && sweep_reg)
            begin
                present_reg   <= acc_present_reg;
                confirmed_reg <= acc_confirmed_reg;
            end
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            if (sweep_reg)
            begin
                out_data_reg <= {ST_CANDIDATE, OUT_IDX_W'(0),
                                 acc_confirmed_reg, acc_present_reg};
                out_user_reg <= 1'b0;
            end
            else
            begin
                out_data_reg <= {res_status_reg, res_idx_reg, confirmed_reg, present_reg};
                out_user_reg <= res_valid_reg;
            end
        end
    end

endmodule

`default_nettype wire

>>> rtl/npt_checker.sv
`timescale 1ns / 1ps
`default_nettype none

module npt_checker
    import npt_pkg::*;
(
    input wire logic                   clk,
    input wire logic                   rst_n,
    input wire logic                   s_axis_tvalid,
    input wire logic                   s_axis_tready,
    input wire logic                   m_axis_tvalid,
    input wire logic                   m_axis_tready,
    input wire logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input wire logic                   m_axis_tuser
);

    // a stalled result stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // one item at a time: ready falls after an input transfer
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while one is in work");

    // no slot fields without a slot
    a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tdata[15:10] == 6'd0)
        else $error("slot fields set on a result with no slot");

    // confirmed entries are a subset of present ones
    a_counts: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[9:5] <= m_axis_tdata[4:0])
        else $error("confirmed count above present count");

    // entry status code is never the unused one
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[15:14] != 2'd3)
        else $error("entry status out of range");

endmodule

bind neighbor_presence_table_top npt_checker u_npt_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire
